[rtl/vdlc_pkg.sv]
// Shared types, codes and sizes for the voltage domain level control unit
`timescale 1ns / 1ps
`default_nettype none
package vdlc_pkg;

  // level table size and derived widths
  localparam int MAX_LEVELS = 16;
  localparam int LVL_AW     = $clog2(MAX_LEVELS);
  localparam int CNT_W      = $clog2(MAX_LEVELS + 1);

  // fixed field widths
  localparam int VOLT_W     = 32;
  localparam int MODE_W     = 8;
  localparam int IDX_W      = 4;
  localparam int CMD_W      = 3;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LCOUNT_W   = 5;
  localparam int DIV_CNT_W  = $clog2(VOLT_W);

  // mode codes
  localparam logic [MODE_W-1:0] MODE_TYPE_ARCH = 8'd0;
  localparam logic [MODE_W-1:0] MODE_ID_OFF    = 8'd0;
  localparam logic [MODE_W-1:0] MODE_ID_ON     = 8'd7;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET_MODE   = 3'd0,
    CMD_SET_MODE   = 3'd1,
    CMD_GET_LEVEL  = 3'd2,
    CMD_SET_LEVEL  = 3'd3,
    CMD_BY_INDEX   = 3'd4,
    CMD_TICK       = 3'd5,
    CMD_LOAD_ENTRY = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_PENDING     = 3'd1,
    ST_BUSY        = 3'd2,
    ST_RANGE       = 3'd3,
    ST_PARAM       = 3'd4,
    ST_UNSUPPORTED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PK_NONE      = 3'd0,
    PK_GET_MODE  = 3'd1,
    PK_SET_MODE  = 3'd2,
    PK_GET_LEVEL = 3'd3,
    PK_SET_LEVEL = 3'd4
  } pend_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_TYPE      = 3'd0,
    CFG_LEVEL_COUNT     = 3'd1,
    CFG_ASYNC_MODE      = 3'd2,
    CFG_DEFAULT_VOLTAGE = 3'd3,
    CFG_DEFAULT_MODE    = 3'd4
  } cfg_reg_t;

  // table read address source
  typedef enum logic {
    ADDR_INDEX = 1'b0,
    ADDR_CNT   = 1'b1
  } addr_sel_t;

  // level check flag update
  typedef enum logic [2:0] {
    OK_HOLD  = 3'd0,
    OK_CLR   = 3'd1,
    OK_MATCH = 3'd2,
    OK_RANGE = 3'd3,
    OK_DIV   = 3'd4
  } ok_op_t;

  // capture of continuous range bounds
  typedef enum logic [1:0] {
    CAP_NONE = 2'd0,
    CAP_LO   = 2'd1,
    CAP_HI   = 2'd2,
    CAP_STEP = 2'd3
  } cap_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH,
    S_CMP,
    S_RD_LO,
    S_RD_HI,
    S_RD_STEP,
    S_RANGE,
    S_DIV,
    S_DIV_CHK,
    S_FINISH
  } ctrl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic      load_in;
    addr_sel_t addr_sel;
    logic      cnt_inc;
    ok_op_t    ok_op;
    cap_t      cap;
    logic      div_init;
    logic      div_step;
    logic      commit;
  } dp_ctrl_t;

  // datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic range_mode;
    logic eff_zero;
    logic cnt_last;
    logic hit;
    logic pre_ok;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/vdlc_req_if.sv]
// Command channel: valid/ready handshake with the command fields
`timescale 1ns / 1ps
`default_nettype none
interface vdlc_req_if;
  logic                valid;
  logic                ready;
  logic [2:0]          command;
  logic signed [31:0]  voltage_in;
  logic [7:0]          mode_type_in;
  logic [7:0]          mode_id_in;
  logic [3:0]          table_index;

  modport source (
    output valid, command, voltage_in, mode_type_in, mode_id_in, table_index,
    input  ready
  );
  modport sink (
    input  valid, command, voltage_in, mode_type_in, mode_id_in, table_index,
    output ready
  );
endinterface
`default_nettype wire

[rtl/vdlc_rsp_if.sv]
// Response channel: valid/ready handshake with the result fields
`timescale 1ns / 1ps
`default_nettype none
interface vdlc_rsp_if;
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic signed [31:0]  voltage_out;
  logic [7:0]          mode_type_out;
  logic [7:0]          mode_id_out;
  logic                is_response;

  modport source (
    output valid, status, voltage_out, mode_type_out, mode_id_out, is_response,
    input  ready
  );
  modport sink (
    input  valid, status, voltage_out, mode_type_out, mode_id_out, is_response,
    output ready
  );
endinterface
`default_nettype wire

[rtl/vdlc_dp.sv]
// Datapath: config and domain state, level table, range divider, response register
`timescale 1ns / 1ps
`default_nettype none
module vdlc_dp
  import vdlc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // command payload
  input  wire logic [CMD_W-1:0]       command,
  input  wire logic signed [VOLT_W-1:0] voltage_in,
  input  wire logic [MODE_W-1:0]      mode_type_in,
  input  wire logic [MODE_W-1:0]      mode_id_in,
  input  wire logic [IDX_W-1:0]       table_index,
  // response
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [STAT_W-1:0]           status,
  output logic signed [VOLT_W-1:0]    voltage_out,
  output logic [MODE_W-1:0]           mode_type_out,
  output logic [MODE_W-1:0]           mode_id_out,
  output logic                        is_response,
  // controller link
  input  wire dp_ctrl_t               ctl,
  output dp_status_t                  sts
);

  // configuration registers
  logic                 range_mode;
  logic [LCOUNT_W-1:0]  entry_count;
  logic                 async_mode;

  // domain state
  logic signed [VOLT_W-1:0] level_now, level_now_next;
  logic [MODE_W-1:0]        mode_now, mode_now_next;
  pend_t                    pend_kind, pend_kind_next;
  logic signed [VOLT_W-1:0] pend_level, pend_level_next;
  logic [MODE_W-1:0]        pend_mode, pend_mode_next;

  // latched command
  cmd_t                     cmd_q;
  logic signed [VOLT_W-1:0] vin_q;
  logic [MODE_W-1:0]        mtype_q;
  logic [MODE_W-1:0]        mid_q;
  logic [IDX_W-1:0]         idx_q;

  // level table
  logic [VOLT_W-1:0] level_table [MAX_LEVELS];
  logic [LVL_AW-1:0] rd_addr;
  logic [VOLT_W-1:0] rd_data;
  logic              wr_en;

  // search and range check
  logic [LVL_AW-1:0]        cnt;
  logic [CNT_W-1:0]         eff_count;
  logic                     lvl_ok;
  logic signed [VOLT_W-1:0] lo_q, hi_q, step_q;

  // serial divider
  logic [VOLT_W-1:0]    dvd, dvs, rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [VOLT_W:0]      rem_sh;
  logic [VOLT_W+1:0]    rem_diff;

  // commit results
  status_t                  st_c;
  logic signed [VOLT_W-1:0] vout_c;
  logic [MODE_W-1:0]        idout_c;
  logic                     resp_c;
  logic                     idx_bad;

  // effective table size
  assign eff_count = (32'(entry_count) > 32'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS)
                                                          : CNT_W'(entry_count);
  assign idx_bad = (32'(idx_q) >= 32'(eff_count)) || (32'(idx_q) >= 32'(MAX_LEVELS));

  // status to controller
  assign sts.cmd        = cmd_q;
  assign sts.range_mode = range_mode;
  assign sts.eff_zero   = (eff_count == '0);
  assign sts.cnt_last   = ((CNT_W'(cnt) + CNT_W'(1)) == eff_count);
  assign sts.hit        = (rd_data == vin_q);
  assign sts.pre_ok     = (step_q != '0) && (vin_q >= lo_q) && (vin_q <= hi_q);
  assign sts.div_last   = (div_cnt == '0);
  assign sts.out_free   = !out_valid || out_ready;

  // table port
  assign rd_addr = (ctl.addr_sel == ADDR_CNT) ? cnt : LVL_AW'(idx_q);

  always_ff @(posedge clk) begin
    rd_data <= level_table[rd_addr];
    if (wr_en) begin
      level_table[LVL_AW'(idx_q)] <= vin_q;
    end
  end

  // command latch
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      cmd_q   <= cmd_t'(command);
      vin_q   <= voltage_in;
      mtype_q <= mode_type_in;
      mid_q   <= mode_id_in;
      idx_q   <= table_index;
    end
  end

  // search counter
  always_ff @(posedge clk) begin
    if (rst || ctl.load_in) begin
      cnt <= '0;
    end else if (ctl.cnt_inc) begin
      cnt <= cnt + LVL_AW'(1);
    end
  end

  // bound capture
  always_ff @(posedge clk) begin
    case (ctl.cap)
      CAP_LO:   lo_q   <= rd_data;
      CAP_HI:   hi_q   <= rd_data;
      CAP_STEP: step_q <= rd_data;
      default: ;
    endcase
  end

  // restoring divider, one quotient bit per cycle, remainder only
  assign rem_sh   = {rem, dvd[VOLT_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      dvd     <= vin_q - lo_q;
      dvs     <= step_q[VOLT_W-1] ? (-step_q) : step_q;
      rem     <= '0;
      div_cnt <= DIV_CNT_W'(VOLT_W - 1);
    end else if (ctl.div_step) begin
      dvd     <= {dvd[VOLT_W-2:0], 1'b0};
      rem     <= rem_diff[VOLT_W+1] ? rem_sh[VOLT_W-1:0] : rem_diff[VOLT_W-1:0];
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // level check flag
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_ok <= 1'b0;
    end else begin
      case (ctl.ok_op)
        OK_CLR:   lvl_ok <= 1'b0;
        OK_MATCH: lvl_ok <= lvl_ok | sts.hit;
        OK_RANGE: lvl_ok <= sts.pre_ok;
        OK_DIV:   lvl_ok <= (rem == '0);
        default:  ;
      endcase
    end
  end

  // result and state update of one command
  always_comb begin
    st_c            = ST_OK;
    vout_c          = '0;
    idout_c         = '0;
    resp_c          = 1'b0;
    wr_en           = 1'b0;
    level_now_next  = level_now;
    mode_now_next   = mode_now;
    pend_kind_next  = pend_kind;
    pend_level_next = pend_level;
    pend_mode_next  = pend_mode;
    case (cmd_q)
      CMD_GET_MODE: begin
        if (!async_mode) begin
          idout_c = mode_now;
        end else if (pend_kind != PK_NONE) begin
          st_c = ST_BUSY;
        end else begin
          st_c            = ST_PENDING;
          pend_kind_next  = PK_GET_MODE;
          pend_level_next = '0;
          pend_mode_next  = '0;
        end
      end
      CMD_SET_MODE: begin
        if (mtype_q != MODE_TYPE_ARCH) begin
          st_c = ST_UNSUPPORTED;
        end else if (mid_q != MODE_ID_OFF && mid_q != MODE_ID_ON) begin
          st_c = ST_PARAM;
        end else if (!async_mode) begin
          mode_now_next = mid_q;
        end else if (pend_kind != PK_NONE) begin
          st_c = ST_BUSY;
        end else begin
          st_c            = ST_PENDING;
          pend_kind_next  = PK_SET_MODE;
          pend_level_next = '0;
          pend_mode_next  = mid_q;
        end
      end
      CMD_GET_LEVEL: begin
        if (!async_mode) begin
          vout_c = level_now;
        end else if (pend_kind != PK_NONE) begin
          st_c = ST_BUSY;
        end else begin
          st_c            = ST_PENDING;
          pend_kind_next  = PK_GET_LEVEL;
          pend_level_next = '0;
          pend_mode_next  = '0;
        end
      end
      CMD_SET_LEVEL: begin
        if (!lvl_ok) begin
          st_c = ST_RANGE;
        end else if (!async_mode) begin
          level_now_next = vin_q;
        end else if (pend_kind != PK_NONE) begin
          st_c = ST_BUSY;
        end else begin
          st_c            = ST_PENDING;
          pend_kind_next  = PK_SET_LEVEL;
          pend_level_next = vin_q;
          pend_mode_next  = '0;
        end
      end
      CMD_BY_INDEX: begin
        if (idx_bad) begin
          st_c = ST_RANGE;
        end else begin
          vout_c = rd_data;
        end
      end
      CMD_TICK: begin
        if (pend_kind != PK_NONE) begin
          resp_c         = 1'b1;
          pend_kind_next = PK_NONE;
          case (pend_kind)
            PK_GET_MODE:  idout_c        = mode_now;
            PK_SET_MODE:  mode_now_next  = pend_mode;
            PK_GET_LEVEL: vout_c         = level_now;
            default:      level_now_next = pend_level;
          endcase
        end
      end
      CMD_LOAD_ENTRY: begin
        wr_en = ctl.commit && (32'(idx_q) < 32'(MAX_LEVELS));
      end
      default: begin
        st_c = ST_UNSUPPORTED;
      end
    endcase
  end

  // configuration and domain state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_mode  <= 1'b0;
      entry_count <= '0;
      async_mode  <= 1'b0;
      level_now   <= '0;
      mode_now    <= '0;
      pend_kind   <= PK_NONE;
      pend_level  <= '0;
      pend_mode   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LEVEL_TYPE:      range_mode  <= cfg_wdata[0];
        CFG_LEVEL_COUNT:     entry_count <= cfg_wdata[LCOUNT_W-1:0];
        CFG_ASYNC_MODE:      async_mode  <= cfg_wdata[0];
        CFG_DEFAULT_VOLTAGE: level_now   <= cfg_wdata[VOLT_W-1:0];
        CFG_DEFAULT_MODE:    mode_now    <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end else if (ctl.commit) begin
      level_now  <= level_now_next;
      mode_now   <= mode_now_next;
      pend_kind  <= pend_kind_next;
      pend_level <= pend_level_next;
      pend_mode  <= pend_mode_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status      <= st_c;
      voltage_out <= vout_c;
      mode_id_out <= idout_c;
      is_response <= resp_c;
    end
  end

  assign mode_type_out = MODE_TYPE_ARCH;

endmodule
`default_nettype wire

[rtl/vdlc_ctrl.sv]
// Controller: sequences table search, range check and commit of one command
`timescale 1ns / 1ps
`default_nettype none
module vdlc_ctrl
  import vdlc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output dp_ctrl_t        ctl
);

  ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ctl          = '0;
    ctl.addr_sel = ADDR_INDEX;
    ctl.ok_op    = OK_HOLD;
    ctl.cap      = CAP_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_in = 1'b1;
          ctl.ok_op   = OK_CLR;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.cmd != CMD_SET_LEVEL) begin
          state_next = S_FINISH;
        end else if (sts.range_mode) begin
          ctl.addr_sel = ADDR_CNT;
          ctl.cnt_inc  = 1'b1;
          state_next   = S_RD_LO;
        end else if (sts.eff_zero) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_SRCH;
        end
      end
      // discrete list: read one entry, then compare
      S_SRCH: begin
        ctl.addr_sel = ADDR_CNT;
        state_next   = S_CMP;
      end
      S_CMP: begin
        ctl.ok_op = OK_MATCH;
        if (sts.hit || sts.cnt_last) begin
          state_next = S_FINISH;
        end else begin
          ctl.cnt_inc = 1'b1;
          state_next  = S_SRCH;
        end
      end
      // continuous range: entries 0, 1, 2 are min, max, step
      S_RD_LO: begin
        ctl.cap      = CAP_LO;
        ctl.addr_sel = ADDR_CNT;
        ctl.cnt_inc  = 1'b1;
        state_next   = S_RD_HI;
      end
      S_RD_HI: begin
        ctl.cap      = CAP_HI;
        ctl.addr_sel = ADDR_CNT;
        state_next   = S_RD_STEP;
      end
      S_RD_STEP: begin
        ctl.cap    = CAP_STEP;
        state_next = S_RANGE;
      end
      S_RANGE: begin
        ctl.ok_op = OK_RANGE;
        if (sts.pre_ok) begin
          ctl.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DIV_CHK;
        end
      end
      S_DIV_CHK: begin
        ctl.ok_op  = OK_DIV;
        state_next = S_FINISH;
      end
      // wait for the response register, then apply
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/voltage_domain_level_control_unit.sv]
// Top level: one voltage domain, a controller and its datapath
// A command passes from the idle state through decode to a commit into the response
// register, which waits until that register is free; a set-level first searches the
// table entries in discrete mode, or reads min, max and step and runs the 32-step remainder unit in continuous mode.
// One command is in work at a time: a new one is taken only once the last is committed.
// Reset (rst, synchronous) clears config, level, mode and pending state, not the table.
`timescale 1ns / 1ps
`default_nettype none
module voltage_domain_level_control_unit
  import vdlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  vdlc_req_if.sink                   req,
  vdlc_rsp_if.source                 rsp
);

  dp_ctrl_t   ctl;
  dp_status_t sts;

  // sequencing
  vdlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // state, table and checks
  vdlc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .command       (req.command),
    .voltage_in    (req.voltage_in),
    .mode_type_in  (req.mode_type_in),
    .mode_id_in    (req.mode_id_in),
    .table_index   (req.table_index),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .voltage_out   (rsp.voltage_out),
    .mode_type_out (rsp.mode_type_out),
    .mode_id_out   (rsp.mode_id_out),
    .is_response   (rsp.is_response),
    .ctl           (ctl),
    .sts           (sts)
  );

endmodule
`default_nettype wire
